### hw/rtl/stb_pkg.sv
// Package for the soft timer bank: sizes, command codes and control structs.
`timescale 1ns / 1ps

package stb_pkg;

    // Number of timer channels (1 to 8).
    localparam int NUM_CHANNELS = 8;
    localparam int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam int KIND_W   = 2;
    localparam int CHAN_W   = 3;
    localparam int PERIOD_W = 16;
    localparam int MASK_W   = 8;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ASSIGN  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ENABLE  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DISABLE = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic load;      // capture input item, clear sweep state
        logic apply;     // execute assign / enable / disable
        logic step;      // service one channel of a tick sweep
        logic out_load;  // move accumulated mask to the output register
    } stb_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_tick;
        logic sweep_last;
        logic out_busy;  // output register holds an item that is not taken this cycle
    } stb_sts_t;

endpackage

### hw/rtl/stb_ctrl.sv
// Controller state machine for the soft timer bank.
`timescale 1ns / 1ps

module stb_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  stb_pkg::stb_sts_t sts,
    output stb_pkg::stb_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cmd.load     = 1'b0;
        cmd.apply    = 1'b0;
        cmd.step     = 1'b0;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!sts.is_tick)
                begin
                    cmd.apply  = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.step = 1'b1;
                    if (sts.sweep_last)
                        state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### hw/rtl/stb_dp.sv
// Datapath for the soft timer bank: channel state, tick sweep and output register.
`timescale 1ns / 1ps

module stb_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [stb_pkg::KIND_W-1:0]      kind,
    input  logic [stb_pkg::CHAN_W-1:0]      channel,
    input  logic [stb_pkg::PERIOD_W-1:0]    period_value,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [stb_pkg::MASK_W-1:0]      fire_mask,
    input  stb_pkg::stb_cmd_t               cmd,
    output stb_pkg::stb_sts_t               sts
);

    localparam int N  = stb_pkg::NUM_CHANNELS;
    localparam int IW = stb_pkg::IDX_W;

    // captured item
    logic [stb_pkg::KIND_W-1:0]   kind_reg;
    logic [stb_pkg::CHAN_W-1:0]   chan_reg;
    logic [stb_pkg::PERIOD_W-1:0] item_period_reg;

    // per-channel state
    logic                         active_reg [N];
    logic                         bound_reg  [N];
    logic [stb_pkg::PERIOD_W-1:0] count_reg  [N];
    logic [stb_pkg::PERIOD_W-1:0] period_reg [N];

    logic [IW-1:0]                sweep_idx_reg;
    logic [stb_pkg::MASK_W-1:0]   mask_reg;
    logic [stb_pkg::MASK_W-1:0]   mask_next;
    logic                         out_valid_reg;
    logic [stb_pkg::MASK_W-1:0]   fire_mask_reg;

    logic [5:0]                   chan_ext;
    logic                         chan_ok;
    logic [IW-1:0]                cmd_idx;
    logic                         run;
    logic                         fire;
    logic [stb_pkg::PERIOD_W-1:0] count_next;

    assign chan_ext = {3'b000, chan_reg};
    assign chan_ok  = (chan_ext < 6'(N));
    assign cmd_idx  = chan_ext[IW-1:0];

    assign run        = active_reg[sweep_idx_reg] && bound_reg[sweep_idx_reg];
    assign fire       = run && (count_reg[sweep_idx_reg] == period_reg[sweep_idx_reg]);
    assign count_next = fire ? '0 : count_reg[sweep_idx_reg] + 1'b1;
    assign mask_next  = mask_reg
                      | (fire ? (stb_pkg::MASK_W'(1) << sweep_idx_reg) : '0);

    assign sts.is_tick    = (kind_reg == stb_pkg::KIND_TICK);
    assign sts.sweep_last = (sweep_idx_reg == IW'(N - 1));
    assign sts.out_busy   = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign fire_mask = fire_mask_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg        <= kind;
            chan_reg        <= channel;
            item_period_reg <= period_value;
        end
        if (cmd.out_load)
            fire_mask_reg <= mask_reg;
    end

    // counters and intervals: one write port, sweep or command
    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            if (run)
                count_reg[sweep_idx_reg] <= count_next;
        end
        else if (cmd.apply && chan_ok)
        begin
            if (kind_reg == stb_pkg::KIND_ASSIGN)
            begin
                count_reg[cmd_idx]  <= '0;
                period_reg[cmd_idx] <= item_period_reg;
            end
            else if (kind_reg == stb_pkg::KIND_ENABLE)
                count_reg[cmd_idx] <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                active_reg[i] <= 1'b0;
                bound_reg[i]  <= 1'b0;
            end
            sweep_idx_reg <= '0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.apply && chan_ok)
            begin
                case (kind_reg)
                    stb_pkg::KIND_ASSIGN:
                    begin
                        active_reg[cmd_idx] <= 1'b1;
                        bound_reg[cmd_idx]  <= 1'b1;
                    end
                    stb_pkg::KIND_ENABLE:  active_reg[cmd_idx] <= 1'b1;
                    stb_pkg::KIND_DISABLE: active_reg[cmd_idx] <= 1'b0;
                    default: ;
                endcase
            end

            if (cmd.load)
            begin
                sweep_idx_reg <= '0;
                mask_reg      <= '0;
            end
            else if (cmd.step)
            begin
                mask_reg <= mask_next;
                if (!sts.sweep_last)
                    sweep_idx_reg <= sweep_idx_reg + 1'b1;
            end

            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // never overwrite an output item that has not been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && !out_ready))
        else $error("output item overwritten");

    // sweep index stays inside the bank
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (32'(sweep_idx_reg) < N))
        else $error("sweep index out of range");

    // commands other than tick report an empty mask
    a_cmd_mask_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && !sts.is_tick) |=> (fire_mask_reg == '0))
        else $error("non-tick item reported fires");

    // a fired channel's counter is cleared
    a_fire_running: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && fire) |=> (count_reg[$past(sweep_idx_reg)] == '0))
        else $error("fired channel counter not cleared");

endmodule

### hw/rtl/soft_timer_bank.sv
// Top level of the soft timer bank: controller plus datapath.
`timescale 1ns / 1ps

// Bank of NUM_CHANNELS periodic timers driven by items on one input channel.
// Input (in_valid/in_ready): kind, channel, period_value. Kind tick advances
// every active, assigned channel; assign loads an interval and starts the
// channel; enable restarts a channel's counter; disable stops it.
// Output (out_valid/out_ready): one fire_mask item per input item, bit n set
// when channel n reached its interval on that tick; zero for other kinds.
// Timing: a tick sweeps the channels one per cycle through the single counter
// update port; assign, enable and disable are applied by one apply command.
// The result is moved to the output register once that register is free.
// in_ready is high only while the controller is idle.
// Reset clears every active and assigned flag and empties the output register.
// Stall: the output register holds the last result while out_ready is low;
// the next item is still accepted and processed, and its result waits in the
// datapath until the output register frees up.
module soft_timer_bank (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [stb_pkg::KIND_W-1:0]    kind,
    input  logic [stb_pkg::CHAN_W-1:0]    channel,
    input  logic [stb_pkg::PERIOD_W-1:0]  period_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [stb_pkg::MASK_W-1:0]    fire_mask
);

    stb_pkg::stb_cmd_t cmd;   // controller commands
    stb_pkg::stb_sts_t sts;   // datapath status

    stb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    stb_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .kind         (kind),
        .channel      (channel),
        .period_value (period_value),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .fire_mask    (fire_mask),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule
